// File: rtl/kva_pkg.sv
package kva_pkg;

	// Width of a stored key index and of the voice number carried in a status byte.
	localparam int KEY_IDX_W = 5;
	localparam int SLOT_W    = 4;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY = 4'd1;

	localparam logic [3:0] OCTAVE_RESET   = 4'd4;
	localparam logic [6:0] VELOCITY_RESET = 7'd100;

	// MIDI message codes and note range.
	localparam logic [7:0] NOTE_ON_CODE  = 8'h90;
	localparam logic [7:0] NOTE_OFF_CODE = 8'h80;
	localparam logic [8:0] NOTE_MAX      = 9'd127;

	// Semitone offset of each of the first keys of the keyboard.
	localparam int OFFSET_ENTRIES = 13;
	localparam int OFFSET_IDX_W   = $clog2(OFFSET_ENTRIES);
	localparam logic [KEY_IDX_W-1:0] KEY_OFFSET_TABLE [OFFSET_ENTRIES] = '{
		5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0, 5'd6,
		5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} kva_state_t;

	// One note message as it leaves the block.
	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] note_number;
		logic [6:0] velocity_byte;
		logic       last_of_scan;
	} kva_msg_t;

	// Request to the voice table: look up a key, and claim or free its slot.
	typedef struct packed {
		logic [KEY_IDX_W-1:0] key;
		logic                 press;
		logic                 commit;
	} kva_vt_req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} kva_vt_rsp_t;

	// Control from the sequencer to the message output stage.
	typedef struct packed {
		logic push;
		logic flush;
	} kva_out_req_t;

	typedef struct packed {
		logic room;
		logic pending;
	} kva_out_sts_t;

	// Keys past the table use their own index as offset.
	function automatic logic [KEY_IDX_W-1:0] kva_key_offset(input logic [KEY_IDX_W-1:0] key);
		logic [KEY_IDX_W-1:0] result;
		if (int'(key) < OFFSET_ENTRIES) begin
			result = KEY_OFFSET_TABLE[key[OFFSET_IDX_W-1:0]];
		end else begin
			result = key;
		end
		return result;
	endfunction

endpackage

// File: rtl/kva_if.sv
// Scan input channel: one beat is one full scan of key levels.
interface kva_scan_if #(parameter int KEY_COUNT = 13);
	logic                 valid;
	logic                 ready;
	logic [KEY_COUNT-1:0] key_levels;

	modport source (output valid, output key_levels, input ready);
	modport sink (input valid, input key_levels, output ready);
endinterface

// Note output channel: one beat is one three-byte MIDI message.
interface kva_note_if;
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	logic [6:0] note_number;
	logic [6:0] velocity_byte;
	logic       last_of_scan;

	modport source (output valid, output status_byte, output note_number,
		output velocity_byte, output last_of_scan, input ready);
	modport sink (input valid, input status_byte, input note_number,
		input velocity_byte, input last_of_scan, output ready);
endinterface

// Configuration write channel.
interface kva_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/kva_voice_table.sv
module kva_voice_table #(
	parameter int VOICE_COUNT = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kva_pkg::kva_vt_req_t req,
	output kva_pkg::kva_vt_rsp_t rsp
);
	import kva_pkg::*;

	logic [KEY_IDX_W-1:0] owner_q [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] valid_q;

	// Priority search: the lowest slot that is free or already owned wins a press,
	// the lowest slot owned by the key wins a release.
	always_comb begin
		logic match;
		logic cand;
		rsp = '0;
		for (int n = 0; n < VOICE_COUNT; n++) begin
			match = (owner_q[n] == req.key);
			cand  = req.press ? (!valid_q[n] || match) : (valid_q[n] && match);
			if (cand && !rsp.hit) begin
				rsp.hit  = 1'b1;
				rsp.slot = SLOT_W'(n);
			end
		end
	end

	// Claim or free the slot that the search found.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int n = 0; n < VOICE_COUNT; n++) begin
				owner_q[n] <= '0;
			end
		end else if (req.commit && rsp.hit) begin
			for (int n = 0; n < VOICE_COUNT; n++) begin
				if (SLOT_W'(n) == rsp.slot) begin
					valid_q[n] <= req.press;
					owner_q[n] <= req.press ? req.key : '0;
				end
			end
		end
	end

endmodule

// File: rtl/kva_msg_out.sv
module kva_msg_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kva_pkg::kva_out_req_t req,
	input  kva_pkg::kva_msg_t    msg,
	output kva_pkg::kva_out_sts_t sts,
	kva_note_if.source           note
);
	import kva_pkg::*;

	// A message waits in the pending register until the next one, or the end of
	// the scan, shows whether it is the last of its scan.
	kva_msg_t pend_q;
	kva_msg_t out_q;
	logic     pend_valid_q;
	logic     out_valid_q;
	logic     out_free;
	logic     room;
	logic     ld_pend;
	logic     ld_shift;
	logic     ld_last;

	always_comb begin
		out_free = !out_valid_q || note.ready;
		room     = !pend_valid_q || out_free;
		ld_pend  = req.push && room;
		ld_shift = ld_pend && pend_valid_q;
		ld_last  = req.flush && !req.push && pend_valid_q && out_free;
		sts.room    = room;
		sts.pending = pend_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= ld_shift || ld_last || (out_valid_q && !note.ready);
			if (ld_pend) begin
				pend_valid_q <= 1'b1;
			end else if (ld_last) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers load without reset.
	always_ff @(posedge clk) begin
		if (ld_pend) begin
			pend_q <= msg;
		end
		if (ld_shift) begin
			out_q <= pend_q;
		end else if (ld_last) begin
			out_q <= '{status_byte: pend_q.status_byte, note_number: pend_q.note_number,
				velocity_byte: pend_q.velocity_byte, last_of_scan: 1'b1};
		end
	end

	assign note.valid         = out_valid_q;
	assign note.status_byte   = out_q.status_byte;
	assign note.note_number   = out_q.note_number;
	assign note.velocity_byte = out_q.velocity_byte;
	assign note.last_of_scan  = out_q.last_of_scan;

endmodule

// File: rtl/key_scan_voice_allocator.sv
// Keyboard scan to MIDI note allocator.
// scan:  one beat carries a full scan of KEY_COUNT active-low key levels.
// note:  one beat carries one MIDI message (status, note, velocity); the final
//        message caused by a scan has last_of_scan set. A scan with no
//        allocated change gives no beat at all.
// cfg:   register writes (index 0 octave, index 1 velocity); always ready,
//        to be used only while the block is idle.
// The sequencer takes the beat in ST_IDLE, steps the single slot search unit
// over the keys in ascending order in ST_WALK, one key per step, and closes
// the scan in ST_FLUSH. scan.ready is high only between scans, so a new scan
// is taken only after the previous one is closed. One message waits in a
// pending register and one in the output register; when both are full and
// note.ready is low, the key walk holds on the changed key until room frees
// up.
// Reset clears the previous scan to all zero (every key seen as pressed),
// frees every voice slot, and sets octave 4 and velocity 100.
module key_scan_voice_allocator #(
	parameter int KEY_COUNT   = 13,
	parameter int VOICE_COUNT = 4
) (
	input logic        clk,
	input logic        arst_n,
	kva_scan_if.sink   scan,
	kva_note_if.source note,
	kva_cfg_if.sink    cfg
);
	import kva_pkg::*;

	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [KW-1:0] LAST_KEY = KW'(KEY_COUNT - 1);

	kva_state_t state_q;
	kva_state_t state_d;

	logic [KW-1:0]        key_q;
	logic [KEY_COUNT-1:0] levels_q;
	logic [KEY_COUNT-1:0] changed_q;
	logic [KEY_COUNT-1:0] prev_q;
	logic [3:0]           octave_q;
	logic [6:0]           velocity_q;

	logic                 scan_ready;
	logic                 step;
	logic                 slot_commit;
	logic                 cur_changed;
	logic [KEY_IDX_W-1:0] cur_key;
	logic [7:0]           note_base;
	logic [8:0]           note_sum;
	logic [6:0]           note_sat;

	kva_vt_req_t  vt_req;
	kva_vt_rsp_t  vt_rsp;
	kva_out_req_t out_req;
	kva_out_sts_t out_sts;
	kva_msg_t     msg;

	// Current key under the walk and the message it would produce.
	always_comb begin
		cur_key       = KEY_IDX_W'(key_q);
		cur_changed   = changed_q[key_q];
		vt_req.key    = cur_key;
		vt_req.press  = !levels_q[key_q];
		vt_req.commit = slot_commit;
		note_base    = {1'b0, octave_q, 3'b000} + {2'b00, octave_q, 2'b00};
		note_sum     = {1'b0, note_base} + {4'b0000, kva_key_offset(cur_key)};
		note_sat     = (note_sum > NOTE_MAX) ? NOTE_MAX[6:0] : note_sum[6:0];
		msg.status_byte   = (vt_req.press ? NOTE_ON_CODE : NOTE_OFF_CODE)
			| {4'b0000, vt_rsp.slot};
		msg.note_number   = note_sat;
		msg.velocity_byte = velocity_q;
		msg.last_of_scan  = 1'b0;
	end

	// Sequencer: next state and control.
	always_comb begin
		state_d     = state_q;
		scan_ready  = 1'b0;
		step        = 1'b0;
		slot_commit = 1'b0;
		out_req     = '0;
		unique case (state_q)
			ST_IDLE: begin
				scan_ready = 1'b1;
				if (scan.valid) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (cur_changed && vt_rsp.hit) begin
					if (out_sts.room) begin
						slot_commit  = 1'b1;
						out_req.push = 1'b1;
						step         = 1'b1;
					end
				end else begin
					step = 1'b1;
				end
				if (step && key_q == LAST_KEY) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				out_req.flush = 1'b1;
				if (out_sts.room) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan capture, key counter and previous scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			prev_q <= '0;
		end else if (scan.valid && scan_ready) begin
			key_q  <= '0;
			prev_q <= scan.key_levels;
		end else if (step) begin
			key_q <= key_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan_ready) begin
			levels_q  <= scan.key_levels;
			changed_q <= scan.key_levels ^ prev_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q   <= OCTAVE_RESET;
			velocity_q <= VELOCITY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_OCTAVE:   octave_q   <= cfg.data[3:0];
				CFG_VELOCITY: velocity_q <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	assign scan.ready = scan_ready;
	assign cfg.ready  = 1'b1;

	kva_voice_table #(
		.VOICE_COUNT(VOICE_COUNT)
	) u_voice_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (vt_req),
		.rsp   (vt_rsp)
	);

	kva_msg_out u_msg_out (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (out_req),
		.msg   (msg),
		.sts   (out_sts),
		.note  (note)
	);

`ifndef SYNTHESIS
	// A new scan is never taken while a message of the previous scan still waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		scan.ready |-> !out_sts.pending)
		else $error("scan taken while a message is pending");

	// Right after a scan beat the block is busy and scan.ready is low.
	assert property (@(posedge clk) disable iff (!arst_n)
		(scan.valid && scan.ready) |=> !scan.ready)
		else $error("scan channel ready right after a scan beat");

	// A message that is not the last of its scan always has a successor waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(note.valid && !note.last_of_scan) |-> out_sts.pending)
		else $error("non-final message without a following message");

	// A slot is claimed or freed only for a changed key under the walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		vt_req.commit |-> (state_q == ST_WALK && cur_changed && vt_rsp.hit))
		else $error("voice slot updated outside a changed key");
`endif

endmodule

// File: tb/kva_note_checker.sv
// Watches the scan, configuration and note channels, predicts the note
// messages of every accepted scan, and compares each note beat with the
// oldest predicted message.
module kva_note_checker
	import kva_pkg::*;
#(
	parameter int KEY_COUNT   = 13,
	parameter int VOICE_COUNT = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  scan_valid,
	input  logic                  scan_ready,
	input  logic [KEY_COUNT-1:0]  key_levels,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  note_valid,
	input  logic                  note_ready,
	input  logic [7:0]            status_byte,
	input  logic [6:0]            note_number,
	input  logic [6:0]            velocity_byte,
	input  logic                  last_of_scan,
	output int                    fail_count,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_KEYS = 13;
	localparam int SEMITONES  = 12;
	localparam int NOTE_TOP   = 127;

	// Semitone offset of each key of the keyboard section.
	localparam logic [KEY_IDX_W-1:0] SEMITONE_OFFSET [TABLE_KEYS] = '{
		5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0, 5'd6,
		5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12
	};

	// Predicted state of the block.
	logic [KEY_COUNT-1:0] held_levels = '0;
	logic [KEY_IDX_W-1:0] slot_key [VOICE_COUNT];
	logic                 slot_busy [VOICE_COUNT];
	logic [3:0]           octave_reg = OCTAVE_RESET;
	logic [6:0]           velocity_reg = VELOCITY_RESET;
	kva_msg_t             expected_notes [$];

	initial begin
		fail_count = 0;
		outstanding = 0;
		for (int n = 0; n < VOICE_COUNT; n++) begin
			slot_key[n] = '0;
			slot_busy[n] = 1'b0;
		end
	end

	// Walk the changed keys in ascending order and queue one message for each
	// key that claims or frees a voice slot.
	task automatic predict_scan(input logic [KEY_COUNT-1:0] levels);
		logic [KEY_COUNT-1:0] changed;
		logic                 pressed;
		int                   slot;
		int                   note;
		int                   k;
		int                   n;
		kva_msg_t             msg;
		kva_msg_t             scan_notes [$];
		changed = levels ^ held_levels;
		for (k = 0; k < KEY_COUNT; k++) begin
			if (changed[k]) begin
				pressed = !levels[k];
				slot = -1;
				for (n = 0; n < VOICE_COUNT && slot < 0; n++) begin
					if (pressed && (!slot_busy[n] || slot_key[n] == k[KEY_IDX_W-1:0])) begin
						slot_busy[n] = 1'b1;
						slot_key[n] = k[KEY_IDX_W-1:0];
						slot = n;
					end else if (!pressed && slot_busy[n] && slot_key[n] == k[KEY_IDX_W-1:0]) begin
						slot_busy[n] = 1'b0;
						slot_key[n] = '0;
						slot = n;
					end
				end
				if (slot >= 0) begin
					if (k < TABLE_KEYS) begin
						note = int'(SEMITONE_OFFSET[k]);
					end else begin
						note = k;
					end
					note = note + int'(octave_reg) * SEMITONES;
					if (note > NOTE_TOP) begin
						note = NOTE_TOP;
					end
					msg.status_byte = (pressed ? NOTE_ON_CODE : NOTE_OFF_CODE) |
						{4'h0, slot[SLOT_W-1:0]};
					msg.note_number = note[6:0];
					msg.velocity_byte = velocity_reg;
					msg.last_of_scan = 1'b0;
					scan_notes.push_back(msg);
				end
			end
		end
		// The final message of the scan carries the end mark.
		if (scan_notes.size() > 0) begin
			msg = scan_notes.pop_back();
			msg.last_of_scan = 1'b1;
			scan_notes.push_back(msg);
		end
		while (scan_notes.size() > 0) begin
			expected_notes.push_back(scan_notes.pop_front());
		end
		held_levels = levels;
	endtask

	// Compare one note beat with the oldest predicted message.
	task automatic check_note();
		kva_msg_t want;
		if (expected_notes.size() == 0) begin
			$display("%0t: unexpected note beat status %h note %h velocity %h last %b",
				$time, status_byte, note_number, velocity_byte, last_of_scan);
			fail_count++;
		end else begin
			want = expected_notes.pop_front();
			if (status_byte !== want.status_byte) begin
				$display("%0t: status_byte expected %h actual %h",
					$time, want.status_byte, status_byte);
				fail_count++;
			end
			if (note_number !== want.note_number) begin
				$display("%0t: note_number expected %h actual %h",
					$time, want.note_number, note_number);
				fail_count++;
			end
			if (velocity_byte !== want.velocity_byte) begin
				$display("%0t: velocity_byte expected %h actual %h",
					$time, want.velocity_byte, velocity_byte);
				fail_count++;
			end
			if (last_of_scan !== want.last_of_scan) begin
				$display("%0t: last_of_scan expected %b actual %b",
					$time, want.last_of_scan, last_of_scan);
				fail_count++;
			end
		end
	endtask

	// Sample every channel at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_levels = '0;
			octave_reg = OCTAVE_RESET;
			velocity_reg = VELOCITY_RESET;
			for (int n = 0; n < VOICE_COUNT; n++) begin
				slot_key[n] = '0;
				slot_busy[n] = 1'b0;
			end
			expected_notes.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_OCTAVE) begin
					octave_reg = cfg_data[3:0];
				end else if (cfg_index == CFG_VELOCITY) begin
					velocity_reg = cfg_data[6:0];
				end
			end
			if (scan_valid && scan_ready) begin
				predict_scan(key_levels);
			end
			if (note_valid && note_ready) begin
				check_note();
			end
			outstanding <= expected_notes.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Drives scans and register writes into the allocator, drains its notes with
// random stalls, and gives the verdict from the checker's failure count.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import kva_pkg::*;

	localparam int KEYS          = 13;
	localparam int VOICES        = 4;
	localparam int SCAN_CYCLES   = KEYS + 2;
	localparam int SETTLE_CYCLES = 2 * SCAN_CYCLES;
	localparam int MAX_GAP       = 18;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_SCANS   = 20;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [KEYS-1:0] ALL_RELEASED = '1;
	localparam logic [KEYS-1:0] ALL_PRESSED  = '0;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   fail_count;
	int   outstanding;
	bit   scan_rush = 1'b0;
	bit   drain_rush = 1'b0;
	logic [KEYS-1:0] levels_now = ALL_RELEASED;

	kva_scan_if #(.KEY_COUNT(KEYS)) scan_ch ();
	kva_note_if note_ch ();
	kva_cfg_if  cfg_ch ();

	key_scan_voice_allocator #(
		.KEY_COUNT  (KEYS),
		.VOICE_COUNT(VOICES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.scan  (scan_ch),
		.note  (note_ch),
		.cfg   (cfg_ch)
	);

	kva_note_checker #(
		.KEY_COUNT  (KEYS),
		.VOICE_COUNT(VOICES)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_valid   (scan_ch.valid),
		.scan_ready   (scan_ch.ready),
		.key_levels   (scan_ch.key_levels),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_index    (cfg_ch.index),
		.cfg_data     (cfg_ch.data),
		.note_valid   (note_ch.valid),
		.note_ready   (note_ch.ready),
		.status_byte  (note_ch.status_byte),
		.note_number  (note_ch.note_number),
		.velocity_byte(note_ch.velocity_byte),
		.last_of_scan (note_ch.last_of_scan),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// Free-running clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one scan beat after a random gap and hold it until it is taken.
	// Called at a clock edge; valid stays high when the next beat follows at once.
	task automatic send_scan(input logic [KEYS-1:0] levels);
		int gap;
		if ($urandom_range(0, 15) == 0) begin
			scan_rush = !scan_rush;
		end
		gap = scan_rush ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			scan_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.key_levels <= levels;
		levels_now = levels;
		do @(posedge clk); while (!scan_ch.ready);
	endtask

	// One register write beat; valid then drops before the task returns.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering scans and wait until every predicted note has left and
	// the last scan has been closed.
	task automatic wait_idle();
		scan_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Next scan: mostly a few keys pressed or released, sometimes a random
	// chord, all keys down, all keys up, or no change.
	function automatic logic [KEYS-1:0] next_scan(input logic [KEYS-1:0] cur);
		logic [KEYS-1:0] nxt;
		int pick;
		int flips;
		int bit_idx;
		pick = $urandom_range(0, 19);
		nxt = cur;
		if (pick < 14) begin
			flips = $urandom_range(1, 3);
			repeat (flips) begin
				bit_idx = $urandom_range(0, KEYS - 1);
				nxt[bit_idx] = ~nxt[bit_idx];
			end
		end else if (pick < 17) begin
			nxt = KEYS'($urandom_range(0, (1 << KEYS) - 1));
		end else if (pick == 17) begin
			nxt = ALL_PRESSED;
		end else if (pick == 18) begin
			nxt = ALL_RELEASED;
		end
		return nxt;
	endfunction

	// Note sink: a random stall before each beat, with stretches of none.
	initial begin
		int stall;
		note_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				drain_rush = !drain_rush;
			end
			stall = drain_rush ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				note_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			note_ch.ready <= 1'b1;
			do @(posedge clk); while (!note_ch.valid);
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n <= 1'b0;
		scan_ch.valid <= 1'b0;
		scan_ch.key_levels <= ALL_RELEASED;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_OCTAVE;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings. The first scan reports releases against an all-pressed
		// history that hold no slot; then slots fill up and surplus keys drop.
		send_scan(ALL_RELEASED);
		send_scan(13'h1FFE);
		send_scan(13'h0FFE);
		send_scan(ALL_PRESSED);
		send_scan(ALL_RELEASED);
		send_scan(ALL_RELEASED);

		// Octave one, zero velocity; releases of keys holding no slot.
		wait_idle();
		write_reg(CFG_OCTAVE, 8'd1);
		write_reg(CFG_VELOCITY, 8'd0);
		send_scan(ALL_PRESSED);
		send_scan(13'h1FF0);
		send_scan(ALL_RELEASED);

		// Out-of-range octave with saturated notes, full data words, and
		// writes to indexes past the register list.
		wait_idle();
		write_reg(CFG_OCTAVE, 8'hFF);
		write_reg(CFG_VELOCITY, 8'hFF);
		write_reg(4'd2, 8'h00);
		write_reg(4'hF, 8'hFF);
		send_scan(13'h0FDF);
		send_scan(ALL_RELEASED);

		// Octave zero; velocity data with only the unused top bit set.
		wait_idle();
		write_reg(CFG_OCTAVE, 8'd0);
		write_reg(CFG_VELOCITY, 8'h80);
		send_scan(13'h1555);
		send_scan(13'h0AAA);
		send_scan(ALL_RELEASED);

		// Octave eight and highest velocity.
		wait_idle();
		write_reg(CFG_OCTAVE, 8'd8);
		write_reg(CFG_VELOCITY, 8'd127);
		send_scan(ALL_PRESSED);
		send_scan(ALL_RELEASED);

		// Random phases, each with its own settings.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			write_reg(CFG_OCTAVE, {4'($urandom_range(0, 15)), 4'($urandom_range(1, 8))});
			write_reg(CFG_VELOCITY, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 2) == 0) begin
				write_reg(4'($urandom_range(2, 15)), 8'($urandom_range(0, 255)));
			end
			for (int i = 0; i < PHASE_SCANS; i++) begin
				send_scan(next_scan(levels_now));
			end
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
